// ===== hdl/bdab_pkg.sv =====
// ----------------------------------------------------------------------------
// bdab_pkg: shared types and constants of the device address book
// Frame query, scan token, slot write command, states, action codes and field widths.
// ----------------------------------------------------------------------------
package bdab_pkg;

	localparam int ADDR_W  = 40;
	localparam int LEN_W   = 3;
	localparam int RATE_W  = 2;
	localparam int MHZ_W   = 12;
	localparam int STR_W   = 7;
	localparam int TIME_W  = 32;
	localparam int CNT_W   = 32;
	localparam int IDX_W   = 6;
	localparam int NDEV_W  = 7;
	localparam int LIMIT_W = 8;

	localparam int MAX_DEVICES_DEF = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd4;
	localparam logic [STR_W-1:0]   STR_DEFAULT = 7'd100;

	// result action codes
	localparam logic [1:0] ACT_UPDATED  = 2'd0;
	localparam logic [1:0] ACT_INSERTED = 2'd1;
	localparam logic [1:0] ACT_REPLACED = 2'd2;
	localparam logic [1:0] ACT_DROPPED  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE
	} state_t;

	// frame held for the whole scan, address already masked to its length
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic [RATE_W-1:0] rate;
		logic [MHZ_W-1:0]  mhz;
		logic [STR_W-1:0]  str;
		logic [TIME_W-1:0] time_ms;
	} query_t;

	// token walking down the cell row
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
		logic [CNT_W-1:0] cnt;
		logic [IDX_W-1:0] wk_idx;
		logic [CNT_W-1:0] wk_cnt;
	} token_t;

	// slot write command broadcast to all cells
	typedef struct packed {
		logic             en;
		logic             fill;
		logic [IDX_W-1:0] idx;
	} wr_t;

	localparam token_t TOKEN_INIT = '{found: 1'b0, idx: '0, cnt: '0,
		wk_idx: '0, wk_cnt: '1};

endpackage

// ===== hdl/busiest_device_address_book.sv =====
// ----------------------------------------------------------------------------
// busiest_device_address_book: table of the most active radio devices
// Looks up each decoded frame, updates, inserts or replaces an entry, or drops the frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one frame per transfer.
//   Output channel (out_valid / out_stall) returns one result per frame:
//   action, touched slot, its packet count and the number of devices.
//   cfg_valid / cfg_ready writes replace_limit; cfg_ready is always high,
//   write it only while no frame is in flight.
// Timing:
//   A frame is registered together with a start flag; the scan token then
//   walks the cell row one slot per cycle, the tail token is latched and
//   a resolve step loads the result. in_stall is high from the cycle after
//   a transfer until the result is issued, so no new frame is taken while
//   one is in flight.
// Reset:
//   arst_n empties the table (device count zero) and sets the limit to 4.
//   Slot contents are not cleared; only slots below the count are used.
// Stall:
//   A result waits in the output register while out_stall is high; a
//   finished scan holds in the resolve step until the register frees up.
// ----------------------------------------------------------------------------
module busiest_device_address_book
	import bdab_pkg::*;
#(
	parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [ADDR_W-1:0]   address,
	input  logic [LEN_W-1:0]    address_length,
	input  logic [RATE_W-1:0]   data_rate,
	input  logic [MHZ_W-1:0]    channel_mhz,
	input  logic [STR_W-1:0]    strength,
	input  logic [TIME_W-1:0]   time_ms,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          action,
	output logic [IDX_W-1:0]    entry_index,
	output logic [CNT_W-1:0]    entry_packets,
	output logic [NDEV_W-1:0]   device_count,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [LIMIT_W-1:0]  cfg_data
);

	state_t state_q, state_d;
	query_t qry_q, qry_d;
	token_t res_q, tail_tok;
	logic   tail_vld, start_q, in_acc, out_free, go;
	logic   len_ok;
	wr_t    wr;
	logic [NDEV_W-1:0]  n_q, n_d;
	logic [LIMIT_W-1:0] limit_q;

	logic              out_valid_q;
	logic [1:0]        action_q, act_d;
	logic [IDX_W-1:0]  index_q, idx_d;
	logic [CNT_W-1:0]  packets_q, pk_d;
	logic [NDEV_W-1:0] count_q;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign go        = (state_q == ST_RESOLVE) && out_free;
	assign cfg_ready = 1'b1;
	assign len_ok    = qry_q.len inside {3'd3, 3'd4, 3'd5};

	// frame capture with address masked to its length
	always_comb begin
		qry_d.len     = address_length;
		qry_d.rate    = data_rate;
		qry_d.mhz     = channel_mhz;
		qry_d.str     = strength;
		qry_d.time_ms = time_ms;
		case (address_length)
			3'd3:    qry_d.addr = {16'd0, address[23:0]};
			3'd4:    qry_d.addr = {8'd0, address[31:0]};
			default: qry_d.addr = address;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			qry_q <= qry_d;
		end
		if (tail_vld) begin
			res_q <= tail_tok;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_acc) state_d = ST_SCAN;
			ST_SCAN:    if (tail_vld) state_d = ST_RESOLVE;
			ST_RESOLVE: if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// resolve: pick action and slot from the finished token
	always_comb begin
		act_d = ACT_DROPPED;
		idx_d = '0;
		pk_d  = '0;
		n_d   = n_q;
		wr    = '{en: 1'b0, fill: 1'b0, idx: '0};
		if (len_ok) begin
			if (res_q.found) begin
				act_d = ACT_UPDATED;
				idx_d = res_q.idx;
				pk_d  = res_q.cnt;
				wr    = '{en: 1'b1, fill: 1'b0, idx: res_q.idx};
			end else if (n_q < NDEV_W'(MAX_DEVICES)) begin
				act_d = ACT_INSERTED;
				idx_d = n_q[IDX_W-1:0];
				pk_d  = CNT_W'(1);
				n_d   = n_q + 1'b1;
				wr    = '{en: 1'b1, fill: 1'b1, idx: n_q[IDX_W-1:0]};
			end else if (res_q.wk_cnt < CNT_W'(limit_q)) begin
				act_d = ACT_REPLACED;
				idx_d = res_q.wk_idx;
				pk_d  = CNT_W'(1);
				wr    = '{en: 1'b1, fill: 1'b1, idx: res_q.wk_idx};
			end
		end
		if (!go) begin
			wr.en = 1'b0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			n_q         <= '0;
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= in_acc;
			if (go) begin
				n_q <= n_d;
			end
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (go) begin
			action_q  <= act_d;
			index_q   <= idx_d;
			packets_q <= pk_d;
			count_q   <= n_d;
		end
	end

	bdab_chain #(
		.MAX_DEVICES(MAX_DEVICES)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.qry      (qry_q),
		.n_valid  (n_q),
		.start    (start_q),
		.tail_tok (tail_tok),
		.tail_vld (tail_vld),
		.wr       (wr)
	);

	assign out_valid     = out_valid_q;
	assign action        = action_q;
	assign entry_index   = index_q;
	assign entry_packets = packets_q;
	assign device_count  = count_q;

`ifndef ASSERT_OFF
	// a transfer always starts a scan that blocks the input
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input not blocked after transfer");

	// the token reaches the tail only while scanning
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail_vld |-> (state_q == ST_SCAN))
		else $error("scan token outside scan");

	// device count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NDEV_W'(MAX_DEVICES))
		else $error("device count above table size");

	// dropped frames report slot and packets as zero
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && action_q == ACT_DROPPED) |-> (index_q == '0 && packets_q == '0))
		else $error("dropped frame with nonzero slot data");
`endif

endmodule

// ===== hdl/bdab_cell.sv =====
// ----------------------------------------------------------------------------
// bdab_cell: one slot of the address book
// Holds one entry, folds it into the passing scan token and applies writes.
// ----------------------------------------------------------------------------
module bdab_cell
	import bdab_pkg::*;
#(
	parameter int CELL_ID = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  query_t            qry,
	input  logic [NDEV_W-1:0] n_valid,
	input  token_t            tok_i,
	input  logic              tok_vld_i,
	output token_t            tok_o,
	output logic              tok_vld_o,
	input  wr_t               wr
);

	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RATE_W-1:0] rate_q;
	logic [MHZ_W-1:0]  mhz_q;
	logic [STR_W-1:0]  str_q;
	logic [TIME_W-1:0] time_q;

	token_t tok_q, tok_d;
	logic   tok_vld_q;
	logic   live, hit, wr_hit;
	logic [CNT_W-1:0] cnt_inc;

	assign live    = NDEV_W'(CELL_ID) < n_valid;
	assign hit     = (len_q == qry.len) && (addr_q == qry.addr);
	assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
	assign wr_hit  = wr.en && (wr.idx == IDX_W'(CELL_ID));

	// fold this slot into the token: first match wins, else track fewest packets
	always_comb begin
		tok_d = tok_i;
		if (!tok_i.found && live) begin
			if (hit) begin
				tok_d.found = 1'b1;
				tok_d.idx   = IDX_W'(CELL_ID);
				tok_d.cnt   = cnt_inc;
			end else if (cnt_q < tok_i.wk_cnt) begin
				tok_d.wk_idx = IDX_W'(CELL_ID);
				tok_d.wk_cnt = cnt_q;
			end
		end
	end

	// token hop to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_vld_i) begin
			tok_q <= tok_d;
		end
	end

	// entry write: fill a new device or refresh a matched one
	always_ff @(posedge clk) begin
		if (wr_hit) begin
			rate_q <= qry.rate;
			mhz_q  <= qry.mhz;
			time_q <= qry.time_ms;
			if (wr.fill) begin
				addr_q <= qry.addr;
				len_q  <= qry.len;
				cnt_q  <= CNT_W'(1);
				str_q  <= (qry.str != '0) ? qry.str : STR_DEFAULT;
			end else begin
				cnt_q <= cnt_inc;
				if (qry.str < str_q) begin
					str_q <= qry.str;
				end
			end
		end
	end

	assign tok_o     = tok_q;
	assign tok_vld_o = tok_vld_q;

endmodule

// ===== hdl/bdab_chain.sv =====
// ----------------------------------------------------------------------------
// bdab_chain: row of address book cells
// Links the cells so the scan token moves one slot per cycle.
// ----------------------------------------------------------------------------
module bdab_chain
	import bdab_pkg::*;
#(
	parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  query_t            qry,
	input  logic [NDEV_W-1:0] n_valid,
	input  logic              start,
	output token_t            tail_tok,
	output logic              tail_vld,
	input  wr_t               wr
);

	token_t tok [MAX_DEVICES+1];
	logic   vld [MAX_DEVICES+1];

	assign tok[0] = TOKEN_INIT;
	assign vld[0] = start;

	for (genvar i = 0; i < MAX_DEVICES; i++) begin : g_cell
		bdab_cell #(
			.CELL_ID(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.qry       (qry),
			.n_valid   (n_valid),
			.tok_i     (tok[i]),
			.tok_vld_i (vld[i]),
			.tok_o     (tok[i+1]),
			.tok_vld_o (vld[i+1]),
			.wr        (wr)
		);
	end

	assign tail_tok = tok[MAX_DEVICES];
	assign tail_vld = vld[MAX_DEVICES];

endmodule
